FILE: rtl/acctilt_pkg.sv
// ----------------------------------------------------------------------------
// acctilt_pkg
// Shared constants, widths and the CORDIC angle table for the tilt block.
// ----------------------------------------------------------------------------
package acctilt_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int ANGLE_WIDTH         = 16;
  localparam int GUARD_BITS          = 8;
  localparam int TABLE_FRAC          = 20;
  localparam int CORDIC_ITERS        = 24;

  // CORDIC working width: covers 2^24 * 1.65 gain plus sign and slack
  localparam int CW = 48;
  // Angle accumulator width: +-2^29 covers +-(180+100) degrees at 20 fraction bits
  localparam int ZW = 32;

  localparam logic signed [ZW-1:0] DEG90  = ZW'(90) <<< TABLE_FRAC;
  localparam logic signed [ZW-1:0] DEG180 = ZW'(180) <<< TABLE_FRAC;

  function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 47185920;
      5'd1:  v = 27855475;
      5'd2:  v = 14718068;
      5'd3:  v = 7471121;
      5'd4:  v = 3750058;
      5'd5:  v = 1876857;
      5'd6:  v = 938658;
      5'd7:  v = 469357;
      5'd8:  v = 234682;
      5'd9:  v = 117342;
      5'd10: v = 58671;
      5'd11: v = 29335;
      5'd12: v = 14668;
      5'd13: v = 7334;
      5'd14: v = 3667;
      5'd15: v = 1833;
      5'd16: v = 917;
      5'd17: v = 458;
      5'd18: v = 229;
      5'd19: v = 115;
      5'd20: v = 57;
      5'd21: v = 29;
      5'd22: v = 14;
      5'd23: v = 7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/acctilt_if.sv
// ----------------------------------------------------------------------------
// acctilt_in_if / acctilt_out_if
// Valid/ready channels carrying an acceleration sample and a pair of angles.
// ----------------------------------------------------------------------------
interface acctilt_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface acctilt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] roll_angle;
  logic [15:0] pitch_angle;
  modport source (output valid, roll_angle, pitch_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

FILE: rtl/acctilt_sqrt.sv
// ----------------------------------------------------------------------------
// acctilt_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ----------------------------------------------------------------------------
module acctilt_sqrt #(
  parameter int IN_W  = 50,
  parameter int TAG_W = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [IN_W-1:0]      radicand,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output logic [IN_W/2-1:0]    root,
  output logic [TAG_W-1:0]     out_tag
);
  import acctilt_pkg::*;

  localparam int RW = IN_W / 2;

  logic [IN_W-1:0]  rem  [RW+1];
  logic [RW-1:0]    res  [RW+1];
  logic [TAG_W-1:0] tag  [RW+1];
  logic             vld  [RW+1];

  always_comb begin
    rem[0] = radicand;
    res[0] = '0;
    tag[0] = in_tag;
    vld[0] = in_valid;
  end

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int SH = 2 * (RW - 1 - k);
    logic [IN_W-1:0] trial;
    logic [IN_W-1:0] top;
    logic [IN_W-1:0] rem_q;
    logic [RW-1:0]   res_q;
    logic [TAG_W-1:0] tag_q;
    logic            vld_q;
    always_comb begin
      // compare (4*res+1) << SH against the remainder
      trial = ((IN_W'(res[k]) << 2) | IN_W'(1)) << SH;
      top   = rem[k];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld[k];
      end
      if (en) begin
        tag_q <= tag[k];
        if (top >= trial) begin
          rem_q <= top - trial;
          res_q <= {res[k][RW-2:0], 1'b1};
        end else begin
          rem_q <= top;
          res_q <= {res[k][RW-2:0], 1'b0};
        end
      end
    end
    assign rem[k+1] = rem_q;
    assign res[k+1] = res_q;
    assign tag[k+1] = tag_q;
    assign vld[k+1] = vld_q;
  end

  assign out_valid = vld[RW];
  assign root      = res[RW];
  assign out_tag   = tag[RW];
endmodule

FILE: rtl/acctilt_cordic.sv
// ----------------------------------------------------------------------------
// acctilt_cordic
// Vectoring CORDIC pipeline: pre-rotation, one rotation per stage, clamp, fold and round.
// ----------------------------------------------------------------------------
module acctilt_cordic #(
  parameter int XW = 32,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [XW-1:0]        num,
  input  logic [XW-1:0]               mag,
  input  logic                        neg_z,
  output logic                        out_valid,
  output logic [15:0]                 angle
);
  import acctilt_pkg::*;

  localparam int S = TABLE_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ZW-1:0] WRAP = ZW'(180) << ANGLE_FRAC_BITS;

  logic signed [CW-1:0] xs [CORDIC_ITERS+1];
  logic signed [CW-1:0] ys [CORDIC_ITERS+1];
  logic signed [ZW-1:0] zs [CORDIC_ITERS+1];
  logic                 zr [CORDIC_ITERS+1];
  logic                 nz [CORDIC_ITERS+1];
  logic                 vl [CORDIC_ITERS+1];

  // pre-rotation stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= in_valid;
    end
    if (en) begin
      nz[0] <= neg_z;
      zr[0] <= (num == '0) && (mag == '0);
      if (num < 0) begin
        xs[0] <= CW'(signed'({1'b0, mag}));
        ys[0] <= -CW'(num);
        zs[0] <= DEG90;
      end else begin
        xs[0] <= CW'(num);
        ys[0] <= CW'(signed'({1'b0, mag}));
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = atan_entry(5'(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
      if (en) begin
        nz[i+1] <= nz[i];
        zr[i+1] <= zr[i];
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ANG;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ANG;
        end
      end
    end
  end

  // clamp, offset and fold
  logic signed [ZW-1:0] zc, phi, phi_f;
  logic                 v_f;
  always_comb begin
    if (zr[CORDIC_ITERS]) zc = '0;
    else if (zs[CORDIC_ITERS] < 0) zc = '0;
    else if (zs[CORDIC_ITERS] > DEG180) zc = DEG180;
    else zc = zs[CORDIC_ITERS];
    phi = nz[CORDIC_ITERS] ? DEG90 - zc : zc - DEG90;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_f <= 1'b0;
    end else if (en) begin
      v_f <= vl[CORDIC_ITERS];
    end
    if (en) begin
      phi_f <= (phi < 0) ? phi + DEG180 : phi;
    end
  end

  // round and wrap 180 back to 0
  logic [ZW-1:0] rnd;
  always_comb begin
    rnd = (ZW'(phi_f) + (ZW'(1) << (S - 1))) >> S;
    if (rnd >= WRAP) rnd = rnd - WRAP;
  end

  logic        v_q;
  logic [15:0] a_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= v_f;
    end
    if (en) begin
      a_q <= rnd[15:0];
    end
  end

  assign out_valid = v_q;
  assign angle     = a_q;
endmodule

FILE: rtl/accel_tilt_angles.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles
// Roll and pitch tilt angles from one three-axis acceleration sample.
// ----------------------------------------------------------------------------
// Fully pipelined: one sample per cycle while the output is not held, no state
// between samples. The pipeline is an absolute-value stage, a squaring stage,
// SAMPLE_WIDTH + 9 square-root stages (one result bit each) and 27 CORDIC
// stages (pre-rotation, 24 rotations, clamp/fold, and round into the output
// register). The whole pipeline advances when the output register is empty or
// being read; a word left waiting at the output holds the pipeline and the
// input. Valid bits travel with the data.
// ----------------------------------------------------------------------------
module accel_tilt_angles #(
  parameter int SAMPLE_WIDTH    = acctilt_pkg::SAMPLE_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = acctilt_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  acctilt_in_if.sink    in_ch,
  acctilt_out_if.source out_ch
);
  import acctilt_pkg::*;

  localparam int SQW = 2 * SAMPLE_WIDTH + 1;            // a1^2 + a2^2
  localparam int RAD = 2 * ((SQW + 2 * GUARD_BITS + 1) / 2); // even radicand width
  localparam int RW  = RAD / 2;
  localparam int XW  = (RW > SAMPLE_WIDTH + GUARD_BITS ? RW : SAMPLE_WIDTH + GUARD_BITS) + 1;
  localparam int TW  = 3 * SAMPLE_WIDTH;

  logic en;
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: absolute values; stage 2: sum of squares
  logic                           v1, v2;
  logic [SAMPLE_WIDTH-1:0]        ax1, ay1, az1;
  logic signed [SAMPLE_WIDTH-1:0] sx1, sy1, sz1;
  logic [SQW-1:0]                 sr2, sp2;
  logic [TW-1:0]                  t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_ch.valid;
      v2 <= v1;
    end
    if (en) begin
      sx1 <= in_ch.accel_x;
      sy1 <= in_ch.accel_y;
      sz1 <= in_ch.accel_z;
      ax1 <= in_ch.accel_x[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_ch.accel_x) : in_ch.accel_x;
      ay1 <= in_ch.accel_y[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_ch.accel_y) : in_ch.accel_y;
      az1 <= in_ch.accel_z[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_ch.accel_z) : in_ch.accel_z;
      sr2 <= SQW'(ay1 * ay1) + SQW'(az1 * az1);
      sp2 <= SQW'(ax1 * ax1) + SQW'(az1 * az1);
      t2  <= {sx1, sy1, sz1};
    end
  end

  logic          rv, pv;
  logic [RW-1:0] rr, pr;
  logic [TW-1:0] rt, pt;

  acctilt_sqrt #(.IN_W(RAD), .TAG_W(TW)) u_sqrt_roll (
    .clk, .rst, .en,
    .in_valid (v2),
    .radicand (RAD'(sr2) << (2 * GUARD_BITS)),
    .in_tag   (t2),
    .out_valid(rv),
    .root     (rr),
    .out_tag  (rt)
  );

  acctilt_sqrt #(.IN_W(RAD), .TAG_W(TW)) u_sqrt_pitch (
    .clk, .rst, .en,
    .in_valid (v2),
    .radicand (RAD'(sp2) << (2 * GUARD_BITS)),
    .in_tag   (t2),
    .out_valid(pv),
    .root     (pr),
    .out_tag  (pt)
  );

  logic signed [SAMPLE_WIDTH-1:0] tx, ty, tz;
  assign {tx, ty, tz} = rt;

  logic        r_ok, p_ok;
  logic [15:0] r_ang, p_ang;

  acctilt_cordic #(.XW(XW), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_roll (
    .clk, .rst, .en,
    .in_valid (rv),
    .num      (XW'(tx) <<< GUARD_BITS),
    .mag      (XW'(rr)),
    .neg_z    (tz[SAMPLE_WIDTH-1]),
    .out_valid(r_ok),
    .angle    (r_ang)
  );

  acctilt_cordic #(.XW(XW), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cordic_pitch (
    .clk, .rst, .en,
    .in_valid (pv),
    .num      (XW'(ty) <<< GUARD_BITS),
    .mag      (XW'(pr)),
    .neg_z    (pt[SAMPLE_WIDTH-1]),
    .out_valid(p_ok),
    .angle    (p_ang)
  );

  assign out_ch.valid       = r_ok & p_ok;
  assign out_ch.roll_angle  = r_ang;
  assign out_ch.pitch_angle = p_ang;
endmodule

FILE: test/accel_tilt_angles_test.sv
// ----------------------------------------------------------------------------
// accel_tilt_angles_test
// Drives acceleration samples into the tilt block and checks every roll and
// pitch word against an in-bench fixed-point CORDIC predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module accel_tilt_angles_test;
  import acctilt_pkg::*;

  typedef struct packed {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } sample_t;

  typedef struct packed {
    logic [15:0] roll;
    logic [15:0] pitch;
  } angles_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 120;
  localparam int N_RANDOM       = 1030;

  logic clk = 1'b0;
  logic rst = 1'b1;

  acctilt_in_if #(.SAMPLE_WIDTH(16)) in_ch ();
  acctilt_out_if out_ch ();

  accel_tilt_angles DUT (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sample_t pending_samples[$];
  angles_t expected_angles[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      n_sent = 0;
  int      idle_cycles = 0;
  int      cycle_cnt = 0;
  bit      stim_done = 1'b0;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned rem, res, bitv;
    rem = v;
    res = 0;
    bitv = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] tilt_of(input longint num, input longint d1,
                                          input longint d2);
    longint deg90, deg180, r, x, y, z, nx, xs, ys, phi;
    longint unsigned a1, a2, rounded;
    deg90  = longint'(90) << TABLE_FRAC;
    deg180 = longint'(180) << TABLE_FRAC;
    a1 = (d1 < 0) ? -d1 : d1;
    a2 = (d2 < 0) ? -d2 : d2;
    r = isqrt64((a1 * a1 + a2 * a2) << (2 * GUARD_BITS));
    x = num * (longint'(1) << GUARD_BITS);
    y = r;
    z = 0;
    if (!(x == 0 && y == 0)) begin
      if (x < 0) begin
        nx = y;
        y = -x;
        x = nx;
        z = deg90;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y > 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(atan_entry(5'(i)));
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(atan_entry(5'(i)));
        end
      end
      if (z < 0) z = 0;
      if (z > deg180) z = deg180;
    end
    phi = z - deg90;
    if (d2 < 0) phi = -phi;
    if (phi < 0) phi = phi + deg180;
    rounded = (unsigned'(phi) + (64'd1 << (TABLE_FRAC - 9)))
              >> (TABLE_FRAC - 8);
    if (rounded >= (64'd180 << 8)) rounded = rounded - (64'd180 << 8);
    return rounded[15:0];
  endfunction

  function automatic angles_t predict_angles(input sample_t s);
    angles_t a;
    a.roll  = tilt_of(s.ax, s.ay, s.az);
    a.pitch = tilt_of(s.ay, s.ax, s.az);
    return a;
  endfunction

  function automatic logic signed [15:0] rand_axis();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'(int'($urandom_range(0, 8)) - 4);
      3: return 16'(int'($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // break with a chance of 18 in 100, except in a quiet window
  function automatic bit take_break();
    if (cycle_cnt >= 400 && cycle_cnt < 800) return 1'b0;
    return $urandom_range(0, 99) < 18;
  endfunction

  initial begin
    logic signed [15:0] corner[5];
    sample_t s;
    corner = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, -16'sh0001};
    pending_samples.push_back('{16'sh0000, 16'sh0000, 16'sh0000});
    for (int i = 0; i < 5; i++) begin
      pending_samples.push_back('{corner[i], corner[(i + 1) % 5], corner[(i + 3) % 5]});
      pending_samples.push_back('{corner[i], corner[i], corner[(i + 2) % 5]});
      pending_samples.push_back('{corner[(i + 4) % 5], 16'sh0000, corner[i]});
    end
    pending_samples.push_back('{16'sh0000, 16'sh0000, 16'sh4000});
    pending_samples.push_back('{16'sh0000, 16'sh0000, -16'sh4000});
    pending_samples.push_back('{16'sh4000, 16'sh0000, 16'sh0000});
    pending_samples.push_back('{-16'sh4000, 16'sh0000, -16'sh0001});
    for (int i = 0; i < N_RANDOM; i++) begin
      s.ax = rand_axis();
      s.ay = rand_axis();
      s.az = rand_axis();
      pending_samples.push_back(s);
    end
    stim_done = 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid   <= 1'b0;
      in_ch.accel_x <= '0;
      in_ch.accel_y <= '0;
      in_ch.accel_z <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        expected_angles.push_back(predict_angles({in_ch.accel_x, in_ch.accel_y,
                                                  in_ch.accel_z}));
        n_sent++;
      end
      if (pending_samples.size() > 0 && !take_break()) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.accel_x <= s.ax;
        in_ch.accel_y <= s.ay;
        in_ch.accel_z <= s.az;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected angle word roll=%0d pitch=%0d",
                 out_ch.roll_angle, out_ch.pitch_angle);
          n_errors++;
        end else begin
          angles_t e;
          e = expected_angles.pop_front();
          if (out_ch.roll_angle !== e.roll) begin
            $error("roll_angle expected %0d actual %0d", e.roll, out_ch.roll_angle);
            n_errors++;
          end
          if (out_ch.pitch_angle !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", e.pitch, out_ch.pitch_angle);
            n_errors++;
          end
          n_checked++;
        end
      end
      out_ch.ready <= !take_break();
    end
  end

  // watchdog: count cycles with no word moving on either side
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        wait (stim_done && pending_samples.size() == 0 && !in_ch.valid
              && expected_angles.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired after %0d idle cycles", idle_cycles);
        n_errors++;
      end
    join_any
    $display("sent %0d samples, checked %0d roll/pitch words", n_sent, n_checked);
    $display("covered axis extremes, zero vector, sign of z and random samples");
    if (n_errors == 0 && expected_angles.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
